### sv/mvt_pkg.sv
// Shared types and constants for the matrix-vector transform unit.
// No dependencies; every other file in this block imports it.
package mvt_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int FIELD_W        = 32;
  localparam int MAT_DIM        = 4;
  localparam int MAT_DEPTH      = MAT_DIM * MAT_DIM;
  localparam int IDX_W          = $clog2(MAT_DEPTH);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_VECTOR = 2'd1,
    OP_POINT  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]                operation;
    logic [IDX_W-1:0]          element_index;
    logic signed [FIELD_W-1:0] element_value;
    logic signed [FIELD_W-1:0] in_x;
    logic signed [FIELD_W-1:0] in_y;
    logic signed [FIELD_W-1:0] in_z;
    logic signed [FIELD_W-1:0] in_w;
  } in_req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic signed [FIELD_W-1:0] out_w;
    logic                      overflow;
  } out_res_t;

  // Load enables for the three datapath stages of a row.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage

### sv/mvt_matrix.sv
// Matrix element store: sixteen registers, row-major, reset to identity.
// Depends on mvt_pkg.
module mvt_matrix
  import mvt_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int OW = (FRAC_BITS + 2 > WORD_WIDTH) ? FRAC_BITS + 2 : WORD_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_idx,
  input  logic signed [FIELD_W-1:0] wr_data,
  output logic signed [OW-1:0]      elem [MAT_DEPTH]
);

  localparam logic signed [OW-1:0] ONE = {{(OW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [OW-1:0] elem_r [MAT_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_DEPTH; i++) begin
        elem_r[i] <= ((i >> 2) == (i & 3)) ? ONE : '0;
      end
    end else if (wr_en) begin
      // Only the low word bits are kept, sign-extended to the operand width.
      elem_r[wr_idx] <= OW'(signed'(wr_data[WORD_WIDTH-1:0]));
    end
  end

  assign elem = elem_r;

endmodule

### sv/mvt_row_pipe.sv
// One row of the transform: four multipliers, a pairwise adder stage, then
// the final add with arithmetic shift and saturation. Depends on mvt_pkg.
module mvt_row_pipe
  import mvt_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int OW = (FRAC_BITS + 2 > WORD_WIDTH) ? FRAC_BITS + 2 : WORD_WIDTH
) (
  input  logic                         clk,
  input  pipe_en_t                     en,
  input  logic signed [OW-1:0]         coef [MAT_DIM],
  input  logic signed [OW-1:0]         vec  [MAT_DIM],
  output logic signed [WORD_WIDTH-1:0] res,
  output logic                         sat
);

  localparam int PW = 2 * OW;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] MAXV = {{(SW-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  logic signed [PW-1:0]         prod_nxt [MAT_DIM];
  logic signed [PW-1:0]         prod_r   [MAT_DIM];
  logic signed [PW:0]           pair_r   [2];
  logic signed [SW-1:0]         sum;
  logic signed [SW-1:0]         shifted;
  logic                         sat_nxt;
  logic signed [WORD_WIDTH-1:0] res_nxt;
  logic signed [WORD_WIDTH-1:0] res_r;
  logic                         sat_r;

  always_comb begin
    for (int c = 0; c < MAT_DIM; c++) begin
      prod_nxt[c] = coef[c] * vec[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_r <= prod_nxt;
    end
    if (en.s2) begin
      pair_r[0] <= (PW+1)'(prod_r[0]) + (PW+1)'(prod_r[1]);
      pair_r[1] <= (PW+1)'(prod_r[2]) + (PW+1)'(prod_r[3]);
    end
    if (en.s3) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  always_comb begin
    sum     = SW'(pair_r[0]) + SW'(pair_r[1]);
    shifted = sum >>> FRAC_BITS;
    sat_nxt = (shifted > MAXV) || (shifted < MINV);
    if (shifted > MAXV) begin
      res_nxt = MAXV[WORD_WIDTH-1:0];
    end else if (shifted < MINV) begin
      res_nxt = MINV[WORD_WIDTH-1:0];
    end else begin
      res_nxt = shifted[WORD_WIDTH-1:0];
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

### sv/matrix_vector_transform_core.sv
// 4x4 matrix times vector or point, signed fixed point with saturation.
// A transform request goes from the input register through the product, pair-sum and result
// registers to out_valid; one request, loads included, is accepted per cycle while in_stall is low.
// A load updates the matrix as it leaves the input register, in time for the next request.
// Reset (synchronous, rst_n low) empties the pipeline and restores the identity matrix.
module matrix_vector_transform_core
  import mvt_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_res
);

  localparam int OW = (FRAC_BITS + 2 > WORD_WIDTH) ? FRAC_BITS + 2 : WORD_WIDTH;
  localparam logic signed [OW-1:0] ONE = {{(OW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic     v0_r, v1_r, v2_r, v3_r;
  logic     pt1_r, pt2_r, pt3_r;
  in_req_t  req0_r;
  logic     rdy0, rdy1, rdy2, rdy3;
  logic     is_xform0, is_point0, is_load0;
  pipe_en_t en;

  logic signed [OW-1:0]         mat  [MAT_DEPTH];
  logic signed [OW-1:0]         vec  [MAT_DIM];
  logic signed [WORD_WIDTH-1:0] row_res [MAT_DIM];
  logic [MAT_DIM-1:0]           row_sat;

  always_comb begin
    is_load0  = (req0_r.operation == OP_LOAD);
    is_point0 = (req0_r.operation == OP_POINT);
    is_xform0 = (req0_r.operation == OP_VECTOR) || is_point0;
  end

  // Each stage moves when it is empty or the stage after it moves. Loads and
  // unused codes retire from the input register without going further.
  always_comb begin
    rdy3 = !v3_r || !out_stall;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;
    rdy0 = !v0_r || !is_xform0 || rdy1;
    en.s1 = rdy1 && v0_r && is_xform0;
    en.s2 = rdy2 && v1_r;
    en.s3 = rdy3 && v2_r;
  end

  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_r <= in_valid;
      end
      if (rdy1) begin
        v1_r <= v0_r && is_xform0;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy0) begin
      req0_r <= in_req;
    end
    if (en.s1) begin
      pt1_r <= is_point0;
    end
    if (en.s2) begin
      pt2_r <= pt1_r;
    end
    if (en.s3) begin
      pt3_r <= pt2_r;
    end
  end

  mvt_matrix #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (v0_r && is_load0),
    .wr_idx  (req0_r.element_index),
    .wr_data (req0_r.element_value),
    .elem    (mat)
  );

  always_comb begin
    vec[0] = OW'(signed'(req0_r.in_x[WORD_WIDTH-1:0]));
    vec[1] = OW'(signed'(req0_r.in_y[WORD_WIDTH-1:0]));
    vec[2] = OW'(signed'(req0_r.in_z[WORD_WIDTH-1:0]));
    vec[3] = is_point0 ? ONE : OW'(signed'(req0_r.in_w[WORD_WIDTH-1:0]));
  end

  for (genvar r = 0; r < MAT_DIM; r++) begin : g_row
    logic signed [OW-1:0] coef [MAT_DIM];

    for (genvar c = 0; c < MAT_DIM; c++) begin : g_col
      assign coef[c] = mat[MAT_DIM * r + c];
    end

    mvt_row_pipe #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_row (
      .clk  (clk),
      .en   (en),
      .coef (coef),
      .vec  (vec),
      .res  (row_res[r]),
      .sat  (row_sat[r])
    );
  end

  // A point transform reports no w component and ignores its saturation.
  always_comb begin
    out_res.out_x    = FIELD_W'(row_res[0]);
    out_res.out_y    = FIELD_W'(row_res[1]);
    out_res.out_z    = FIELD_W'(row_res[2]);
    out_res.out_w    = pt3_r ? '0 : FIELD_W'(row_res[3]);
    out_res.overflow = row_sat[0] || row_sat[1] || row_sat[2] || (row_sat[3] && !pt3_r);
  end

  assign out_valid = v3_r;

endmodule
